FILE: hw/rtl/dlr_pkg.sv
// Shared constants for the styled DDA line rasterizer.
// Standalone package; the rasterizer top level imports it.
package dlr_pkg;

  // Default geometry and dot spacing
  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned DOT_PERIOD_DEF = 4;

  // APB register port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  // Register indexes (byte address is 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_START_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_X      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_Y      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LINE_STYLE = 3'd4;

  // Line style codes; the unused code draws as normal
  localparam int unsigned STYLE_W = 2;
  localparam logic [STYLE_W-1:0] STYLE_NORMAL = 2'd0;
  localparam logic [STYLE_W-1:0] STYLE_DOTTED = 2'd1;
  localparam logic [STYLE_W-1:0] STYLE_BOLD   = 2'd2;

endpackage

FILE: hw/rtl/dda_line_rasterizer_styled.sv
// Styled DDA line rasterizer: APB endpoint/style registers, tick input, pixel output.
// Depends on dlr_pkg for default parameters, register indexes and style codes.
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  tick    | in_valid_i, in_stall_o, restart_i                 | in
//  pixel   | out_valid_o, out_stall_i, pixel_x_o, pixel_y_o,   | out
//          | last_of_step_o, line_done_o                       |
//  config  | psel, penable, pwrite, paddr, pwdata, prdata,     | in/out
//          | pready                                            |
//
// Per tick: an advance tick emits the pixels of one step (normal 1, bold 4 as a 2x2 block,
//   a dotted gap none); a tick with no line in progress is taken and ignored.
// A restart tick runs the shared restoring divider, one quotient bit a cycle,
//   x increment first and then y; a zero-length line skips the divider.
// The output register holds one pixel; out_stall_i holds it and pauses the pixel
//   sequencer. in_stall_o is high while a tick is being worked on.
// Reset clears the line state; no line is active until a restart tick.
module dda_line_rasterizer_styled #(
  parameter int unsigned COORD_BITS = dlr_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF,
  parameter int unsigned DOT_PERIOD = dlr_pkg::DOT_PERIOD_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            restart_i,
  // pixel channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [COORD_BITS:0]             pixel_x_o,
  output logic [COORD_BITS:0]             pixel_y_o,
  output logic                            last_of_step_o,
  output logic                            line_done_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dlr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dlr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dlr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import dlr_pkg::*;

  localparam int unsigned ACC_W = COORD_BITS + FRAC_BITS;  // unsigned Q(C).(F)
  localparam int unsigned INC_W = FRAC_BITS + 2;           // signed Q1.(F)
  localparam int unsigned QUO_W = FRAC_BITS + 1;           // quotient magnitude
  localparam int unsigned REM_W = COORD_BITS + 1;          // divider remainder
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned DOT_W = $clog2(DOT_PERIOD);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [STYLE_W-1:0]    style_q;
  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      style_q   <= STYLE_NORMAL;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_X:    start_x_q <= pwdata[COORD_BITS-1:0];
        REG_START_Y:    start_y_q <= pwdata[COORD_BITS-1:0];
        REG_END_X:      end_x_q   <= pwdata[COORD_BITS-1:0];
        REG_END_Y:      end_y_q   <= pwdata[COORD_BITS-1:0];
        REG_LINE_STYLE: style_q   <= pwdata[STYLE_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_X:    prdata = APB_DATA_W'(start_x_q);
      REG_START_Y:    prdata = APB_DATA_W'(start_y_q);
      REG_END_X:      prdata = APB_DATA_W'(end_x_q);
      REG_END_Y:      prdata = APB_DATA_W'(end_y_q);
      REG_LINE_STYLE: prdata = APB_DATA_W'(style_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Line state, divider and pixel sequencer
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [ACC_W-1:0]      x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [INC_W-1:0]      x_inc_q, x_inc_d, y_inc_q, y_inc_d;
  logic [COORD_BITS-1:0] step_q, step_d, total_q, total_d;
  logic                  active_q, active_d;
  logic [DOT_W-1:0]      dot_q, dot_d;
  logic [1:0]            pix_q, pix_d;
  // divider
  logic                  axis_q, axis_d;      // 0: x increment, 1: y increment
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic                  x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic [COORD_BITS-1:0] ay_q, ay_d;
  // output register
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS:0]   px_out_q, px_out_d, py_out_q, py_out_d;
  logic                  last_q, last_d, done_out_q, done_out_d;

  // Restart arithmetic on the configured endpoints
  logic                  dx_neg, dy_neg;
  logic [COORD_BITS-1:0] ax, ay, steps;
  assign dx_neg = end_x_q < start_x_q;
  assign dy_neg = end_y_q < start_y_q;
  assign ax     = dx_neg ? start_x_q - end_x_q : end_x_q - start_x_q;
  assign ay     = dy_neg ? start_y_q - end_y_q : end_y_q - start_y_q;
  assign steps  = (ax > ay) ? ax : ay;

  // Shared compare/subtract unit of the restoring divider
  logic             div_ge;
  logic [REM_W-1:0] div_diff, div_keep;
  logic [QUO_W-1:0] quo_next;
  logic [INC_W-1:0] inc_mag, inc_signed;
  logic             div_last;
  assign div_ge     = rem_q >= {1'b0, total_q};
  assign div_diff   = rem_q - {1'b0, total_q};
  assign div_keep   = div_ge ? div_diff : rem_q;
  assign quo_next   = {quo_q[QUO_W-2:0], div_ge};
  assign inc_mag    = {1'b0, quo_next};
  assign inc_signed = (axis_q ? y_neg_q : x_neg_q) ? INC_W'(0) - inc_mag : inc_mag;
  assign div_last   = cnt_q == CNT_W'(FRAC_BITS);

  // Rounded pixel position: (acc + half) >> FRAC_BITS, round half up
  logic [ACC_W:0]      x_round, y_round;
  logic [COORD_BITS:0] px, py;
  assign x_round = {1'b0, x_acc_q} + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
  assign y_round = {1'b0, y_acc_q} + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
  assign px      = x_round[ACC_W:FRAC_BITS];
  assign py      = y_round[ACC_W:FRAC_BITS];

  // Pixels of the current step
  logic is_bold, emit_any, pix_last, step_done;
  assign is_bold   = style_q == STYLE_BOLD;
  assign emit_any  = !((style_q == STYLE_DOTTED) && (dot_q != '0));
  assign pix_last  = !is_bold || (pix_q == 2'd3);
  assign step_done = step_q == total_q;

  always_comb begin
    state_d     = state_q;
    x_acc_d     = x_acc_q;
    y_acc_d     = y_acc_q;
    x_inc_d     = x_inc_q;
    y_inc_d     = y_inc_q;
    step_d      = step_q;
    total_d     = total_q;
    active_d    = active_q;
    dot_d       = dot_q;
    pix_d       = pix_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    ay_d        = ay_q;
    out_valid_d = out_valid_q && out_stall_i;
    px_out_d    = px_out_q;
    py_out_d    = py_out_q;
    last_d      = last_q;
    done_out_d  = done_out_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            // Latch the endpoints and load the start point
            total_d  = steps;
            x_acc_d  = {start_x_q, FRAC_BITS'(0)};
            y_acc_d  = {start_y_q, FRAC_BITS'(0)};
            step_d   = '0;
            dot_d    = '0;
            pix_d    = '0;
            active_d = 1'b1;
            x_neg_d  = dx_neg;
            y_neg_d  = dy_neg;
            ay_d     = ay;
            if (steps == '0) begin
              // Zero-length line: a single step, no division
              x_inc_d = '0;
              y_inc_d = '0;
              state_d = S_EMIT;
            end else begin
              axis_d  = 1'b0;
              cnt_d   = '0;
              rem_d   = {1'b0, ax};
              quo_d   = '0;
              state_d = S_DIV;
            end
          end else if (active_q) begin
            pix_d   = '0;
            state_d = S_EMIT;
          end
        end
      end

      S_DIV: begin
        rem_d = {div_keep[REM_W-2:0], 1'b0};
        quo_d = quo_next;
        cnt_d = cnt_q + CNT_W'(1);
        if (div_last) begin
          cnt_d = '0;
          quo_d = '0;
          if (!axis_q) begin
            x_inc_d = inc_signed;
            axis_d  = 1'b1;
            rem_d   = {1'b0, ay_q};
          end else begin
            y_inc_d = inc_signed;
            state_d = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!emit_any || !out_valid_q || !out_stall_i) begin
          if (emit_any) begin
            out_valid_d = 1'b1;
            px_out_d    = px + (COORD_BITS + 1)'(is_bold & pix_q[0]);
            py_out_d    = py + (COORD_BITS + 1)'(is_bold & pix_q[1]);
            last_d      = pix_last;
            done_out_d  = step_done;
          end
          if (!emit_any || pix_last) begin
            // Step complete: advance the line or end it
            pix_d   = '0;
            state_d = S_IDLE;
            if (step_done) begin
              active_d = 1'b0;
            end else begin
              x_acc_d = x_acc_q + {{(ACC_W - INC_W){x_inc_q[INC_W-1]}}, x_inc_q};
              y_acc_d = y_acc_q + {{(ACC_W - INC_W){y_inc_q[INC_W-1]}}, y_inc_q};
              step_d  = step_q + COORD_BITS'(1);
              dot_d   = (dot_q == DOT_W'(DOT_PERIOD - 1)) ? '0 : dot_q + DOT_W'(1);
            end
          end else begin
            pix_d = pix_q + 2'd1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      x_inc_q     <= '0;
      y_inc_q     <= '0;
      step_q      <= '0;
      total_q     <= '0;
      active_q    <= 1'b0;
      dot_q       <= '0;
      pix_q       <= '0;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      ay_q        <= '0;
      out_valid_q <= 1'b0;
      px_out_q    <= '0;
      py_out_q    <= '0;
      last_q      <= 1'b0;
      done_out_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_acc_q     <= x_acc_d;
      y_acc_q     <= y_acc_d;
      x_inc_q     <= x_inc_d;
      y_inc_q     <= y_inc_d;
      step_q      <= step_d;
      total_q     <= total_d;
      active_q    <= active_d;
      dot_q       <= dot_d;
      pix_q       <= pix_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      x_neg_q     <= x_neg_d;
      y_neg_q     <= y_neg_d;
      ay_q        <= ay_d;
      out_valid_q <= out_valid_d;
      px_out_q    <= px_out_d;
      py_out_q    <= py_out_d;
      last_q      <= last_d;
      done_out_q  <= done_out_d;
    end
  end

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = px_out_q;
  assign pixel_y_o      = py_out_q;
  assign last_of_step_o = last_q;
  assign line_done_o    = done_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A new pixel is only loaded by the pixel sequencer
  a_pixel_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("pixel loaded outside the emit state");

  // The divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (total_q != '0))
    else $error("divider running on a zero-length line");

  // The step index never passes the final step of an active line
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (step_q <= total_q))
    else $error("step index beyond the final step");

  // A line ends only at its final step, in the pixel sequencer
  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> $past((state_q == S_EMIT) && (step_q == total_q)))
    else $error("line ended before its final step");

endmodule
